// ===== hdl/deq_pkg.sv =====
package deq_pkg;

    localparam int CAPACITY   = 16;
    localparam int WORD_BITS  = 32;
    localparam int FIELD_BITS = 32;
    localparam int COUNT_BITS = 5;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SUM_W      = CNT_W + 1;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_REAR   = 3'd3;
    localparam logic [2:0] REQ_QUERY      = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic        [2:0]            req_type;
        logic signed [FIELD_BITS-1:0] push_value;
    } t_deq_in;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] pop_value;
        logic        [1:0]            status;
        logic        [COUNT_BITS-1:0] entry_count;
        logic                         is_empty;
        logic signed [FIELD_BITS-1:0] front_value;
        logic signed [FIELD_BITS-1:0] rear_value;
    } t_deq_out;

    function automatic t_word field_to_word(logic signed [FIELD_BITS-1:0] v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[WORD_BITS-1:0];
    endfunction

    function automatic logic signed [FIELD_BITS-1:0] word_to_field(t_word w);
        logic signed [WORD_BITS-1:0] s;
        logic signed [63:0]          wide;
        s    = w;
        wide = 64'(s);
        return wide[FIELD_BITS-1:0];
    endfunction

endpackage

// ===== hdl/double_ended_queue.sv =====
// Double-ended queue of signed words held in a ring buffer of CAPACITY entries.
// Input channel: i_in_valid / o_in_stall carry a request (push front, push
// rear, pop front, pop rear or query) with its push word. Output channel:
// o_out_valid / i_out_stall carry one result per request: the popped word,
// the status, the entry count, the empty flag and the front and rear words.
// A transfer happens on a rising edge where valid is high and stall is low.
// Front and rear words are cached in registers; the ring memory has one
// write port and one registered read port. Pushes, queries, failed pops and
// pops that leave at most one word produce their result in the cycle after the
// transfer and the next request may follow at once. A pop that leaves two or
// more words reads the new end word from the memory in a fetch state first.
// The result sits in an output register; a new request is taken only when
// that register is empty or drains in the same cycle, so a stalled receiver
// holds off the input side after one result. Synchronous reset empties the
// queue and drops any pending result; memory contents are not cleared.
module double_ended_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  deq_pkg::t_deq_in i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output deq_pkg::t_deq_out o_out
);
    import deq_pkg::*;

    typedef enum logic {S_IDLE, S_FETCH} t_state;

    t_state              r_state, n_state;
    logic                r_out_valid, n_out_valid;
    t_deq_out            r_out, n_out;
    logic [IDX_W-1:0]    r_front_idx, n_front_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    t_word               r_front_word, n_front_word;
    t_word               r_rear_word, n_rear_word;
    t_word               r_pop_word, n_pop_word;
    logic                r_fetch_front, n_fetch_front;

    t_word               r_mem [CAPACITY];
    t_word               r_rd_data;
    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_addr;
    logic [IDX_W-1:0]    w_rd_addr;
    t_word               w_word;
    logic                w_accept;
    logic [IDX_W-1:0]    w_front_dec;
    logic [IDX_W-1:0]    w_front_inc;
    logic [IDX_W-1:0]    w_tail_idx;
    logic [IDX_W-1:0]    w_rear_prev;
    logic                w_full;
    logic                w_empty;
    logic                w_many;

    function automatic logic [IDX_W-1:0] ring_pos(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic t_deq_out make_out(t_word pop_w, logic [1:0] status,
                                          logic [CNT_W-1:0] cnt, t_word fw, t_word rw);
        t_deq_out res;
        res.pop_value   = word_to_field(pop_w);
        res.status      = status;
        res.entry_count = COUNT_BITS'(cnt);
        res.is_empty    = (cnt == '0);
        res.front_value = (cnt == '0) ? '0 : word_to_field(fw);
        res.rear_value  = (cnt == '0) ? '0 : word_to_field(rw);
        return res;
    endfunction

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_word      = field_to_word(i_in.push_value);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);
    assign w_many      = (r_count > CNT_W'(2));
    assign w_front_dec = (r_front_idx == '0) ? IDX_W'(CAPACITY - 1) : r_front_idx - 1'b1;
    assign w_front_inc = (r_front_idx == IDX_W'(CAPACITY - 1)) ? '0 : r_front_idx + 1'b1;
    assign w_tail_idx  = ring_pos(r_front_idx, r_count);
    assign w_rear_prev = ring_pos(r_front_idx, r_count - CNT_W'(2));

    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out         = r_out;
        n_front_idx   = r_front_idx;
        n_count       = r_count;
        n_front_word  = r_front_word;
        n_rear_word   = r_rear_word;
        n_pop_word    = '0;
        n_fetch_front = r_fetch_front;
        w_wr_en       = 1'b0;
        w_wr_addr     = w_tail_idx;
        w_rd_addr     = w_rear_prev;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_out       = make_out('0, ST_OK, r_count, r_front_word, r_rear_word);
                    case (i_in.req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                            if (w_full) begin
                                n_out.status = ST_OVERFLOW;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + 1'b1;
                                if (i_in.req_type == REQ_PUSH_FRONT) begin
                                    w_wr_addr    = w_front_dec;
                                    n_front_idx  = w_front_dec;
                                    n_front_word = w_word;
                                    if (w_empty) begin
                                        n_rear_word = w_word;
                                    end
                                end else begin
                                    n_rear_word = w_word;
                                    if (w_empty) begin
                                        n_front_word = w_word;
                                    end
                                end
                                n_out = make_out('0, ST_OK, n_count, n_front_word,
                                                 n_rear_word);
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_REAR: begin
                            if (w_empty) begin
                                n_out.status = ST_UNDERFLOW;
                            end else begin
                                n_count = r_count - 1'b1;
                                if (i_in.req_type == REQ_POP_FRONT) begin
                                    n_pop_word    = r_front_word;
                                    n_front_idx   = w_front_inc;
                                    n_front_word  = r_rear_word;
                                    n_fetch_front = 1'b1;
                                    w_rd_addr     = w_front_inc;
                                end else begin
                                    n_pop_word    = r_rear_word;
                                    n_rear_word   = r_front_word;
                                    n_fetch_front = 1'b0;
                                end
                                if (w_many) begin
                                    n_state     = S_FETCH;
                                    n_out_valid = 1'b0;
                                end else begin
                                    n_out = make_out(n_pop_word, ST_OK, n_count,
                                                     n_front_word, n_rear_word);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                if (r_fetch_front) begin
                    n_front_word = r_rd_data;
                end else begin
                    n_rear_word = r_rd_data;
                end
                n_out = make_out(r_pop_word, ST_OK, r_count, n_front_word, n_rear_word);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_front_idx <= '0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_front_idx <= n_front_idx;
            r_count     <= n_count;
        end
        r_out         <= n_out;
        r_front_word  <= n_front_word;
        r_rear_word   <= n_rear_word;
        r_pop_word    <= n_pop_word;
        r_fetch_front <= n_fetch_front;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_word;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

endmodule

// ===== hdl/deq_checker.sv =====
module deq_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input deq_pkg::t_deq_out o_out
);
    import deq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.is_empty == (o_out.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_empty_words: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.is_empty |-> (o_out.front_value == '0)
                                          && (o_out.rear_value == '0))
        else $error("front or rear word nonzero on empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.entry_count <= COUNT_BITS'(CAPACITY)))
        else $error("entry count above capacity");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
